/* rtl/suv_pkg.sv */
// shared types and constants for the set union and intersection engine
package suv_pkg;

  localparam int VALUE_W     = 32;
  localparam int REQ_COUNT_W = 11;
  localparam int CFG_DATA_W  = 11;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_PULL  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic {
    CFG_SET_OPERATION  = 1'b0,
    CFG_REQUIRED_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_SCAN,
    ST_UNION_READ,
    ST_ISECT_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic                      result_valid;
    logic                      final_result;
    logic                      overflowed;
  } out_t;

  typedef struct packed {
    logic                   set_operation;
    logic [REQ_COUNT_W-1:0] required_count;
  } cfg_t;

  // smallest qualifying value seen in a scan, and whether a runner-up was seen
  typedef struct packed {
    logic                      found;
    logic                      more;
    logic signed [VALUE_W-1:0] best;
  } rank_t;

endpackage

/* rtl/suv_rank.sv */
// keeps the two smallest qualifying values offered during an intersection scan
module suv_rank (
  input  logic                               clk,
  input  logic                               clr,
  input  logic                               feed,
  input  logic signed [suv_pkg::VALUE_W-1:0] value,
  output suv_pkg::rank_t                     rank
);

  logic                               have_best;
  logic                               have_second;
  logic signed [suv_pkg::VALUE_W-1:0] best;
  logic signed [suv_pkg::VALUE_W-1:0] second;

  always_ff @(posedge clk) begin
    if (clr) begin
      have_best   <= 1'b0;
      have_second <= 1'b0;
    end else if (feed) begin
      if (!have_best || value < best) begin
        best        <= value;
        have_best   <= 1'b1;
        second      <= best;
        have_second <= have_best;
      end else if (!have_second || value < second) begin
        second      <= value;
        have_second <= 1'b1;
      end
    end
  end

  assign rank.found = have_best;
  assign rank.more  = have_second;
  assign rank.best  = best;

endmodule

/* rtl/suv_ctrl.sv */
// table memory and the sequencer that searches, appends and scans it
module suv_ctrl #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  suv_pkg::in_t   in_data,
  input  suv_pkg::cfg_t  cfg,
  output logic           res_push,
  input  logic           res_ready,
  output suv_pkg::out_t  res
);

  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int AW   = $clog2(MAX_ITEMS);
  localparam int DW   = suv_pkg::VALUE_W + CW;
  localparam int CMPW = (CW > suv_pkg::REQ_COUNT_W) ? CW : suv_pkg::REQ_COUNT_W;

  // each entry holds {count, value}
  logic [DW-1:0] mem [MAX_ITEMS];
  logic [DW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;

  suv_pkg::state_t state, state_next;
  logic [CW-1:0] total, total_next;
  logic [CW-1:0] loaded, loaded_next;
  logic [CW-1:0] cursor, cursor_next;
  logic signed [suv_pkg::VALUE_W-1:0] last_emitted, last_emitted_next;
  logic          emitted_any, emitted_any_next;
  logic          overflow, overflow_next;
  logic [CW-1:0] scan_addr, scan_addr_next;
  logic          pend, pend_next;
  logic [AW-1:0] pend_idx, pend_idx_next;
  logic signed [suv_pkg::VALUE_W-1:0] load_val, load_val_next;
  suv_pkg::out_t res_q, res_next;

  logic                               in_fire;
  logic                               issue;
  logic signed [suv_pkg::VALUE_W-1:0] rd_value;
  logic [CW-1:0]                      rd_count;
  logic                               qualifies;
  logic                               rank_clr;
  logic                               rank_feed;
  suv_pkg::rank_t                     rank;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  suv_rank u_rank (
    .clk   (clk),
    .clr   (rank_clr),
    .feed  (rank_feed),
    .value (rd_value),
    .rank  (rank)
  );

  assign in_ready = (state == suv_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign res_push = (state == suv_pkg::ST_EMIT);
  assign res      = res_q;

  assign rd_value  = $signed(rd_data[suv_pkg::VALUE_W-1:0]);
  assign rd_count  = rd_data[DW-1:suv_pkg::VALUE_W];
  assign issue     = (scan_addr < total);
  assign qualifies = (CMPW'(rd_count) == CMPW'(cfg.required_count)) &&
                     (!emitted_any || rd_value > last_emitted);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= suv_pkg::ST_IDLE;
      total        <= '0;
      loaded       <= '0;
      cursor       <= '0;
      last_emitted <= '0;
      emitted_any  <= 1'b0;
      overflow     <= 1'b0;
      pend         <= 1'b0;
    end else begin
      state        <= state_next;
      total        <= total_next;
      loaded       <= loaded_next;
      cursor       <= cursor_next;
      last_emitted <= last_emitted_next;
      emitted_any  <= emitted_any_next;
      overflow     <= overflow_next;
      pend         <= pend_next;
    end
    scan_addr <= scan_addr_next;
    pend_idx  <= pend_idx_next;
    load_val  <= load_val_next;
    res_q     <= res_next;
  end

  always_comb begin
    state_next        = state;
    total_next        = total;
    loaded_next       = loaded;
    cursor_next       = cursor;
    last_emitted_next = last_emitted;
    emitted_any_next  = emitted_any;
    overflow_next     = overflow;
    scan_addr_next    = scan_addr;
    pend_next         = 1'b0;
    pend_idx_next     = pend_idx;
    load_val_next     = load_val;
    res_next          = res_q;
    rd_addr           = scan_addr[AW-1:0];
    mem_we            = 1'b0;
    mem_waddr         = pend_idx;
    mem_wdata         = {CW'(1), load_val};
    rank_clr          = 1'b0;
    rank_feed         = 1'b0;

    unique case (state)
      suv_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.func)
            suv_pkg::FUNC_LOAD: begin
              if (loaded == CW'(MAX_ITEMS)) begin
                overflow_next = 1'b1;
              end else begin
                loaded_next    = loaded + CW'(1);
                load_val_next  = in_data.value;
                scan_addr_next = '0;
                state_next     = suv_pkg::ST_LOAD_SCAN;
              end
            end
            suv_pkg::FUNC_PULL: begin
              if (!cfg.set_operation) begin
                if (cursor < total) begin
                  rd_addr    = cursor[AW-1:0];
                  state_next = suv_pkg::ST_UNION_READ;
                end else begin
                  res_next.result_value = '0;
                  res_next.result_valid = 1'b0;
                  res_next.final_result = 1'b0;
                  res_next.overflowed   = overflow;
                  state_next            = suv_pkg::ST_EMIT;
                end
              end else begin
                rank_clr       = 1'b1;
                scan_addr_next = '0;
                state_next     = suv_pkg::ST_ISECT_SCAN;
              end
            end
            suv_pkg::FUNC_CLEAR: begin
              total_next        = '0;
              loaded_next       = '0;
              cursor_next       = '0;
              last_emitted_next = '0;
              emitted_any_next  = 1'b0;
              overflow_next     = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      suv_pkg::ST_LOAD_SCAN: begin
        // reads run one entry ahead of the compare
        if (issue) begin
          scan_addr_next = scan_addr + CW'(1);
          pend_next      = 1'b1;
          pend_idx_next  = scan_addr[AW-1:0];
        end
        if (pend && rd_value == load_val) begin
          mem_we     = 1'b1;
          mem_waddr  = pend_idx;
          mem_wdata  = {rd_count + CW'(1), load_val};
          pend_next  = 1'b0;
          state_next = suv_pkg::ST_IDLE;
        end else if (!issue && !pend) begin
          mem_we     = 1'b1;
          mem_waddr  = total[AW-1:0];
          mem_wdata  = {CW'(1), load_val};
          total_next = total + CW'(1);
          state_next = suv_pkg::ST_IDLE;
        end
      end

      suv_pkg::ST_UNION_READ: begin
        res_next.result_value = rd_value;
        res_next.result_valid = 1'b1;
        res_next.final_result = ((cursor + CW'(1)) == total);
        res_next.overflowed   = overflow;
        cursor_next           = cursor + CW'(1);
        state_next            = suv_pkg::ST_EMIT;
      end

      suv_pkg::ST_ISECT_SCAN: begin
        if (issue) begin
          scan_addr_next = scan_addr + CW'(1);
          pend_next      = 1'b1;
        end
        rank_feed = pend && qualifies;
        if (!issue && !pend) begin
          res_next.overflowed = overflow;
          if (rank.found) begin
            res_next.result_value = rank.best;
            res_next.result_valid = 1'b1;
            res_next.final_result = !rank.more;
            last_emitted_next     = rank.best;
            emitted_any_next      = 1'b1;
          end else begin
            res_next.result_value = '0;
            res_next.result_valid = 1'b0;
            res_next.final_result = 1'b0;
          end
          state_next = suv_pkg::ST_EMIT;
        end
      end

      suv_pkg::ST_EMIT: begin
        if (res_ready) begin
          state_next = suv_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = suv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/set_union_intersection_engine.sv */
// Set union / intersection engine. Loads search the table one entry per cycle over the
// single-read-port table memory; a load stops at the first entry that holds its value and
// otherwise appends a new entry. A union pull reads the entry, captures it and hands it off to
// the output register, and hands off an empty result when no value is left; an intersection
// pull scans every stored entry once. Clear, func 3 and a load into a full table leave the
// engine idle and ready for the next beat. A pull holds the engine for as long as the output
// register keeps an earlier result that has not been taken. Table entries beyond the distinct
// count are never read, so no clearing pass runs after reset. One item is worked on at a time;
// a finished result waits in an output register while the next item is accepted.
module set_union_intersection_engine #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  suv_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output suv_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [suv_pkg::CFG_DATA_W-1:0]     cfg_data
);

  suv_pkg::cfg_t cfg;
  suv_pkg::out_t res;
  logic          res_push;
  logic          res_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_operation  <= 1'b0;
      cfg.required_count <= suv_pkg::REQ_COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        suv_pkg::CFG_SET_OPERATION:  cfg.set_operation  <= cfg_data[0];
        suv_pkg::CFG_REQUIRED_COUNT: cfg.required_count <= cfg_data[suv_pkg::REQ_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  suv_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .res_push  (res_push),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register parts the result from the next item
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_push && res_ready) begin
      out_data <= res;
    end
  end

`ifndef SYNTH
  a_pull_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.func == suv_pkg::FUNC_PULL |=> !in_ready)
    else $error("pull beat did not start a table access");

  a_clear_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.func == suv_pkg::FUNC_CLEAR |=> in_ready)
    else $error("clear beat held the engine busy");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.result_valid |-> !out_data.final_result &&
      out_data.result_value == '0)
    else $error("empty result carries a value or final mark");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    res_push && res_ready |=> out_valid)
    else $error("result lost on the way to the output register");
`endif

endmodule

/* test/set_union_checker.sv */
// checker for the set union and intersection engine: table model, expected pull results, compare
module set_union_checker #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  suv_pkg::in_t                   in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  suv_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [suv_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fails,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // model of the table and the pull progress
  logic signed [suv_pkg::VALUE_W-1:0] table_vals [TABLE_DEPTH];
  logic [suv_pkg::REQ_COUNT_W-1:0]    table_cnts [TABLE_DEPTH];
  int                                 distinct_total;
  int                                 items_loaded;
  int                                 union_cursor;
  logic signed [suv_pkg::VALUE_W-1:0] last_emitted;
  bit                                 emitted_any;
  bit                                 overflow_seen;
  bit                                 isect_mode;
  logic [suv_pkg::REQ_COUNT_W-1:0]    req_count;

  suv_pkg::out_t                      pull_results_q [$];
  suv_pkg::out_t                      want;

  task automatic clear_table();
    distinct_total = 0;
    items_loaded   = 0;
    union_cursor   = 0;
    last_emitted   = '0;
    emitted_any    = 1'b0;
    overflow_seen  = 1'b0;
  endtask

  // smallest value with the required count, strictly above bound when bounded
  function automatic bit smallest_above(input bit bounded,
                                        input logic signed [suv_pkg::VALUE_W-1:0] bound,
                                        output logic signed [suv_pkg::VALUE_W-1:0] found);
    bit                                 have;
    logic signed [suv_pkg::VALUE_W-1:0] best;
    logic signed [suv_pkg::VALUE_W-1:0] cand;
    have = 1'b0;
    best = '0;
    for (int i = 0; i < distinct_total; i++) begin
      cand = table_vals[i];
      if (table_cnts[i] == req_count && !(bounded && cand <= bound) &&
          (!have || cand < best)) begin
        best = cand;
        have = 1'b1;
      end
    end
    found = best;
    return have;
  endfunction

  task automatic step_table(input suv_pkg::in_t item);
    logic signed [suv_pkg::VALUE_W-1:0] v;
    logic signed [suv_pkg::VALUE_W-1:0] nxt;
    logic signed [suv_pkg::VALUE_W-1:0] spare;
    suv_pkg::out_t                      r;
    bit                                 hit;
    v = item.value;
    r = '0;
    case (item.func)
      suv_pkg::FUNC_LOAD: begin
        if (items_loaded >= TABLE_DEPTH) begin
          overflow_seen = 1'b1;
        end else begin
          items_loaded++;
          hit = 1'b0;
          for (int i = 0; i < distinct_total && !hit; i++) begin
            if (table_vals[i] == v) begin
              table_cnts[i] = table_cnts[i] + 1'b1;
              hit = 1'b1;
            end
          end
          if (!hit) begin
            table_vals[distinct_total] = v;
            table_cnts[distinct_total] = suv_pkg::REQ_COUNT_W'(1);
            distinct_total++;
          end
        end
      end
      suv_pkg::FUNC_PULL: begin
        if (!isect_mode) begin
          if (union_cursor < distinct_total) begin
            r.result_value = table_vals[union_cursor];
            union_cursor++;
            r.result_valid = 1'b1;
            r.final_result = (union_cursor == distinct_total);
          end
        end else if (smallest_above(emitted_any, last_emitted, nxt)) begin
          r.result_value = nxt;
          r.result_valid = 1'b1;
          last_emitted   = nxt;
          emitted_any    = 1'b1;
          r.final_result = !smallest_above(1'b1, nxt, spare);
        end
        r.overflowed = overflow_seen;
        pull_results_q.push_back(r);
      end
      suv_pkg::FUNC_CLEAR: clear_table();
      default: ;
    endcase
  endtask

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d got %0d", $time, field, $signed(exp_v),
               $signed(got_v));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_table();
      isect_mode = 1'b0;
      req_count  = suv_pkg::REQ_COUNT_W'(1);
      fails      = 0;
      pull_results_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pull_results_q.size() == 0) begin
          fails++;
          $display("%0t: result beat with no pull outstanding, expected none got value %0d",
                   $time, out_data.result_value);
        end else begin
          want = pull_results_q.pop_front();
          check_field("result_value", want.result_value, out_data.result_value);
          check_field("result_valid", 32'(want.result_valid), 32'(out_data.result_valid));
          check_field("final_result", 32'(want.final_result), 32'(out_data.final_result));
          check_field("overflowed", 32'(want.overflowed), 32'(out_data.overflowed));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == suv_pkg::CFG_SET_OPERATION) isect_mode = cfg_data[0];
        else req_count = cfg_data;
      end
      if (in_valid && in_ready) step_table(in_data);
    end
    pending = pull_results_q.size();
  end

endmodule

/* test/testbench.sv */
// top of the engine testbench: clock, reset, stimulus, idling phases and the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 1024;
  localparam int SETTLE      = TABLE_DEPTH + 64;
  localparam int QUIET_LIMIT = 20000;
  localparam int TOTAL_ITEMS = 580;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic signed [suv_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [suv_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  suv_pkg::in_t                   in_data;
  logic                           out_valid;
  logic                           out_ready;
  suv_pkg::out_t                  out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic                           cfg_index;
  logic [suv_pkg::CFG_DATA_W-1:0] cfg_data;

  int fails;
  int pending;
  int gap_pct;
  int stall_pct;
  int items_sent;
  int quiet_cycles;

  set_union_intersection_engine #(.MAX_ITEMS(TABLE_DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  set_union_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 51; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 51; end
      default: begin gap_pct = 7; stall_pct = 7; end
    endcase
  endtask

  // called at a rising edge; returns at the edge where the beat is taken, valid left high
  task automatic send_item(input logic [1:0] f, input logic signed [suv_pkg::VALUE_W-1:0] v);
    suv_pkg::in_t beat;
    bit           taken;
    beat.func  = f;
    beat.value = v;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    items_sent++;
  endtask

  // hold off until every pull has answered
  task automatic pause_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // loads give no result beat, so let a last table search finish as well
  task automatic wait_drained();
    pause_for_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input suv_pkg::cfg_idx_t idx,
                           input logic [suv_pkg::CFG_DATA_W-1:0] data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input bit isect, input logic [suv_pkg::CFG_DATA_W-1:0] req);
    logic [suv_pkg::CFG_DATA_W-1:0] op_word;
    // upper bits of the operation word are don't-care
    op_word = (suv_pkg::CFG_DATA_W'($urandom) & ~suv_pkg::CFG_DATA_W'(1)) |
              suv_pkg::CFG_DATA_W'(isect);
    wait_drained();
    write_reg(suv_pkg::CFG_SET_OPERATION, op_word);
    write_reg(suv_pkg::CFG_REQUIRED_COUNT, req);
  endtask

  function automatic logic [suv_pkg::CFG_DATA_W-1:0] pick_required();
    case ($urandom_range(0, 11))
      0: return suv_pkg::CFG_DATA_W'(0);
      1: return suv_pkg::CFG_DATA_W'(TABLE_DEPTH);
      2: return '1;
      3: return suv_pkg::CFG_DATA_W'($urandom);
      default: return suv_pkg::CFG_DATA_W'($urandom_range(1, 3));
    endcase
  endfunction

  initial begin
    logic signed [suv_pkg::VALUE_W-1:0] pool [8];
    int n_loads;
    int n_pulls;
    int fresh_pct;
    int seq;

    clk       = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = suv_pkg::CFG_SET_OPERATION;
    cfg_data  = '0;
    gap_pct   = 0;
    stall_pct = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pull, extremes, repeats, ignored func, union then intersection
    set_mode(1'b0, suv_pkg::CFG_DATA_W'(1));
    send_item(suv_pkg::FUNC_PULL, '0);
    send_item(suv_pkg::FUNC_LOAD, VAL_MIN);
    send_item(suv_pkg::FUNC_LOAD, VAL_MAX);
    send_item(suv_pkg::FUNC_LOAD, 0);
    send_item(suv_pkg::FUNC_LOAD, -1);
    send_item(suv_pkg::FUNC_LOAD, VAL_MIN);
    send_item(suv_pkg::FUNC_LOAD, 1);
    send_item(suv_pkg::FUNC_LOAD, VAL_MAX);
    send_item(FUNC_UNUSED, 32'sh5A5A_A5A5);
    repeat (6) send_item(suv_pkg::FUNC_PULL, '0);
    set_mode(1'b1, suv_pkg::CFG_DATA_W'(2));
    send_item(suv_pkg::FUNC_PULL, '0);
    // loads between pulls keep intersection progress
    send_item(suv_pkg::FUNC_LOAD, 5);
    send_item(suv_pkg::FUNC_LOAD, 5);
    repeat (3) send_item(suv_pkg::FUNC_PULL, '0);
    send_item(suv_pkg::FUNC_CLEAR, '0);
    send_item(suv_pkg::FUNC_PULL, '0);

    seq = 0;
    while (items_sent < TOTAL_ITEMS) begin
      set_idling(seq);
      if ($urandom_range(0, 1) == 0) set_mode(1'($urandom_range(0, 1)), pick_required());
      if ($urandom_range(0, 7) == 0) begin
        // noise: any func, any value
        repeat (10) send_item(2'($urandom_range(0, 3)), $urandom);
      end else begin
        for (int i = 0; i < 8; i++) begin
          case ($urandom_range(0, 5))
            0: pool[i] = VAL_MIN;
            1: pool[i] = VAL_MAX;
            2: pool[i] = $urandom_range(0, 3) - 1;
            default: pool[i] = $urandom;
          endcase
        end
        if ($urandom_range(0, 3) != 0) send_item(suv_pkg::FUNC_CLEAR, $urandom);
        if ($urandom_range(0, 9) == 0) begin
          n_loads   = $urandom_range(60, 160);
          fresh_pct = 50;
        end else begin
          n_loads   = $urandom_range(1, 24);
          fresh_pct = 10;
        end
        for (int i = 0; i < n_loads; i++) begin
          if ($urandom_range(99) < fresh_pct) send_item(suv_pkg::FUNC_LOAD, $urandom);
          else send_item(suv_pkg::FUNC_LOAD, pool[$urandom_range(0, 7)]);
          if ($urandom_range(0, 5) == 0) send_item(suv_pkg::FUNC_PULL, $urandom);
        end
        if ($urandom_range(0, 5) == 0) pause_for_results();
        n_pulls = (n_loads > 30) ? $urandom_range(5, 40) : $urandom_range(1, n_loads + 3);
        repeat (n_pulls) send_item(suv_pkg::FUNC_PULL, $urandom);
        // mode flip mid-way keeps each mode's progress
        if ($urandom_range(0, 3) == 0) begin
          set_mode(1'($urandom_range(0, 1)), pick_required());
          repeat ($urandom_range(1, 6)) send_item(suv_pkg::FUNC_PULL, $urandom);
        end
      end
      seq++;
    end

    pause_for_results();
    repeat (SETTLE) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
